// ===== design/cs_pkg.sv =====
// cs_pkg: shared constants, codes, types and knee table for the curve shaper.
// Used by the channel interfaces, the decode stage, the top level and the checker.
// No dependencies.
package cs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int XW        = FRAC_BITS + 1;
    localparam int RW        = FRAC_BITS + 4;
    localparam int PW1       = XW + RW;
    localparam int PW        = 2 * XW;
    localparam int NSTG      = 7;

    localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
    localparam longint unsigned SQ_L  = 64'd1 << (2 * FRAC_BITS);

    localparam logic [XW-1:0] ONE  = XW'(ONE_L);
    localparam logic [XW-1:0] HALF = XW'(ONE_L >> 1);

    localparam longint unsigned KNEE_90 = ONE_L * 9 / 10;
    localparam longint unsigned KNEE_85 = ONE_L * 17 / 20;
    localparam longint unsigned KNEE_75 = ONE_L * 3 / 4;
    localparam longint unsigned KNEE_50 = ONE_L * 1 / 2;
    localparam longint unsigned SPAN_90 = ONE_L - KNEE_90;
    localparam longint unsigned SPAN_85 = ONE_L - KNEE_85;
    localparam longint unsigned SPAN_75 = ONE_L - KNEE_75;
    localparam longint unsigned SPAN_50 = ONE_L - KNEE_50;
    localparam longint unsigned RCP_90  = SQ_L / SPAN_90;
    localparam longint unsigned RCP_85  = SQ_L / SPAN_85;
    localparam longint unsigned RCP_75  = SQ_L / SPAN_75;
    localparam longint unsigned RCP_50  = SQ_L / SPAN_50;

    localparam logic [7:0] FN_LIN    = 8'd0;
    localparam logic [7:0] FN_STEP   = 8'd1;
    localparam logic [7:0] FN_GL90   = 8'd2;
    localparam logic [7:0] FN_GL85   = 8'd3;
    localparam logic [7:0] FN_GL75   = 8'd4;
    localparam logic [7:0] FN_GL50   = 8'd5;
    localparam logic [7:0] FN_QDN    = 8'd6;
    localparam logic [7:0] FN_QUP    = 8'd7;
    localparam logic [7:0] FN_TRI    = 8'd8;
    localparam logic [7:0] FN_SMOOTH = 8'd9;

    typedef enum logic [2:0] {
        KD_DIRECT,
        KD_GLISS,
        KD_QDN,
        KD_QUP,
        KD_SMOOTH
    } t_kind;

    typedef struct packed {
        logic [XW-1:0]        knee;
        logic [FRAC_BITS-1:0] span;
        logic [RW-1:0]        rcp;
    } t_knee;

    typedef struct packed {
        t_kind                kind;
        logic [XW-1:0]        res;
        logic [XW-1:0]        x;
        logic [XW-1:0]        a;
        logic [XW-1:0]        d;
        logic [RW-1:0]        b;
        logic [FRAC_BITS-1:0] span;
    } t_dec;

    // rcp = floor(2^(2F) / span); quotient estimate is low by at most one
    function automatic t_knee knee_of(input logic [1:0] sel);
        t_knee k;
        case (sel)
            2'd0: k = '{knee: XW'(KNEE_90), span: FRAC_BITS'(SPAN_90), rcp: RW'(RCP_90)};
            2'd1: k = '{knee: XW'(KNEE_85), span: FRAC_BITS'(SPAN_85), rcp: RW'(RCP_85)};
            2'd2: k = '{knee: XW'(KNEE_75), span: FRAC_BITS'(SPAN_75), rcp: RW'(RCP_75)};
            default: k = '{knee: XW'(KNEE_50), span: FRAC_BITS'(SPAN_50), rcp: RW'(RCP_50)};
        endcase
        return k;
    endfunction

endpackage

// ===== design/cs_if.sv =====
// cs_in_if / cs_out_if: valid-ready channels for input and result items.
// Depends on cs_pkg for the sample width.
interface cs_in_if import cs_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [XW-1:0] phase_in;
    logic [7:0]    func;

    modport source (output valid, output phase_in, output func, input ready);
    modport sink   (input valid, input phase_in, input func, output ready);
endinterface

interface cs_out_if import cs_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [XW-1:0] shaped_out;

    modport source (output valid, output shaped_out, input ready);
    modport sink   (input valid, input shaped_out, output ready);
endinterface

// ===== design/cs_decode.sv =====
// cs_decode: input saturation, curve classification and first multiplier operands.
// Depends on cs_pkg (codes, knee table, t_dec).
module cs_decode import cs_pkg::*; (
    input  logic [XW-1:0] i_phase_in,
    input  logic [7:0]    i_func,
    output t_dec          o_dec
);

    logic [XW-1:0] w_x;
    logic [XW-1:0] w_y;
    logic [XW-1:0] w_hi;
    t_knee         w_kn;

    assign w_x  = (i_phase_in > ONE) ? ONE : i_phase_in;
    assign w_y  = ONE - w_x;
    assign w_hi = w_x - HALF;
    assign w_kn = knee_of(2'(i_func - FN_GL90));

    always_comb begin
        o_dec      = '0;
        o_dec.kind = KD_DIRECT;
        o_dec.res  = w_x;
        o_dec.x    = w_x;
        o_dec.a    = w_x;
        o_dec.b    = RW'(w_x);
        case (i_func)
            FN_LIN: begin
                o_dec.res = w_x;
            end
            FN_STEP: begin
                o_dec.res = '0;
            end
            FN_GL90, FN_GL85, FN_GL75, FN_GL50: begin
                if (w_x < w_kn.knee) begin
                    o_dec.res = '0;
                end else begin
                    o_dec.kind = KD_GLISS;
                    o_dec.d    = w_x - w_kn.knee;
                    o_dec.a    = w_x - w_kn.knee;
                    o_dec.b    = w_kn.rcp;
                    o_dec.span = w_kn.span;
                end
            end
            FN_QDN: begin
                o_dec.kind = KD_QDN;
                o_dec.a    = w_y;
                o_dec.b    = RW'(w_y);
            end
            FN_QUP: begin
                o_dec.kind = KD_QUP;
            end
            FN_TRI: begin
                if (w_x > HALF) begin
                    o_dec.res = ONE - {w_hi[XW-2:0], 1'b0};
                end else begin
                    o_dec.res = {w_x[XW-2:0], 1'b0};
                end
            end
            FN_SMOOTH: begin
                o_dec.kind = KD_SMOOTH;
            end
            default: begin
                o_dec.res = w_x;
            end
        endcase
    end

endmodule

// ===== design/curve_shaper_core.sv =====
// Throughput: one item per cycle while no result waits on o_out.ready.
// Four multiply stages (reciprocal divide, quotient correction, two for the cube) set the depth.
// The whole pipe holds while a result waits on o_out.ready; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data registers are not reset.
// Depends on cs_pkg, cs_if and cs_decode.
module curve_shaper_core import cs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cs_in_if.sink     i_in,
    cs_out_if.source  o_out
);

    logic            w_en;
    t_dec            w_dec;
    logic [NSTG-1:0] r_vld;

    // stage 1
    t_kind                r_s1_kind;
    logic [XW-1:0]        r_s1_res, r_s1_x, r_s1_a, r_s1_d;
    logic [RW-1:0]        r_s1_b;
    logic [FRAC_BITS-1:0] r_s1_span;
    // stage 2
    t_kind                r_s2_kind;
    logic [XW-1:0]        r_s2_res, r_s2_x, r_s2_d;
    logic [PW1-1:0]       r_s2_p;
    logic [FRAC_BITS-1:0] r_s2_span;
    // stage 3
    t_kind                r_s3_kind;
    logic [XW-1:0]        r_s3_res, r_s3_q, r_s3_d;
    logic [PW-1:0]        r_s3_p;
    logic [FRAC_BITS-1:0] r_s3_span;
    // stages 4..7
    logic                 r_s4_gl, r_s5_gl, r_s6_gl;
    logic [XW-1:0]        r_s4_res, r_s5_res, r_s6_res, r_s7_res;
    logic [PW-1:0]        r_s5_p, r_s6_p;

    logic [PW1-1:0]  n_p1;
    logic [XW-1:0]   n_q, n_b2, n_s3_res;
    t_kind           n_s3_kind;
    logic [PW-1:0]   n_p2, n_num, n_rem, n_p3, n_p4;
    logic            n_ge;
    logic [XW-1:0]   n_f, n_c, n_s4_res, n_s7_res;
    logic [XW+1:0]   n_sm;

    cs_decode u_dec (
        .i_phase_in (i_in.phase_in),
        .i_func     (i_in.func),
        .o_dec      (w_dec)
    );

    assign w_en       = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    // stage 2: first product (d * rcp or square)
    assign n_p1 = PW1'(r_s1_a) * PW1'(r_s1_b);

    // stage 3: quotient estimate, correction product, quadratic results
    assign n_q  = r_s2_p[FRAC_BITS +: XW];
    assign n_b2 = (r_s2_kind == KD_GLISS) ? XW'(r_s2_span) : r_s2_x;
    assign n_p2 = PW'(n_q) * PW'(n_b2);

    always_comb begin
        n_s3_kind = r_s2_kind;
        n_s3_res  = r_s2_res;
        case (r_s2_kind)
            KD_QUP: begin
                n_s3_kind = KD_DIRECT;
                n_s3_res  = n_q;
            end
            KD_QDN: begin
                n_s3_kind = KD_DIRECT;
                n_s3_res  = ONE - n_q;
            end
            default: begin
                n_s3_kind = r_s2_kind;
            end
        endcase
    end

    // stage 4: quotient correction, smoothstep combine
    assign n_num = PW'({r_s3_d, FRAC_BITS'(0)});
    assign n_rem = n_num - r_s3_p;
    assign n_ge  = n_rem >= PW'(r_s3_span);
    assign n_f   = r_s3_q + XW'(n_ge);
    assign n_c   = r_s3_p[FRAC_BITS +: XW];
    assign n_sm  = (XW+2)'(r_s3_q) + ((XW+2)'(r_s3_q) << 1) - ((XW+2)'(n_c) << 1);

    always_comb begin
        case (r_s3_kind)
            KD_GLISS:  n_s4_res = n_f;
            KD_SMOOTH: n_s4_res = (n_sm > (XW+2)'(ONE)) ? ONE : XW'(n_sm);
            default:   n_s4_res = r_s3_res;
        endcase
    end

    // stages 5..7: cube of the gliss fraction
    assign n_p3     = PW'(r_s4_res) * PW'(r_s4_res);
    assign n_p4     = PW'(r_s5_p[FRAC_BITS +: XW]) * PW'(r_s5_res);
    assign n_s7_res = r_s6_gl ? r_s6_p[FRAC_BITS +: XW] : r_s6_res;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_kind <= w_dec.kind;
            r_s1_res  <= w_dec.res;
            r_s1_x    <= w_dec.x;
            r_s1_a    <= w_dec.a;
            r_s1_d    <= w_dec.d;
            r_s1_b    <= w_dec.b;
            r_s1_span <= w_dec.span;

            r_s2_kind <= r_s1_kind;
            r_s2_res  <= r_s1_res;
            r_s2_x    <= r_s1_x;
            r_s2_d    <= r_s1_d;
            r_s2_p    <= n_p1;
            r_s2_span <= r_s1_span;

            r_s3_kind <= n_s3_kind;
            r_s3_res  <= n_s3_res;
            r_s3_q    <= n_q;
            r_s3_d    <= r_s2_d;
            r_s3_p    <= n_p2;
            r_s3_span <= r_s2_span;

            r_s4_gl   <= (r_s3_kind == KD_GLISS);
            r_s4_res  <= n_s4_res;

            r_s5_gl   <= r_s4_gl;
            r_s5_res  <= r_s4_res;
            r_s5_p    <= n_p3;

            r_s6_gl   <= r_s5_gl;
            r_s6_res  <= r_s5_res;
            r_s6_p    <= n_p4;

            r_s7_res  <= n_s7_res;
        end
    end

    assign o_out.valid      = r_vld[NSTG-1];
    assign o_out.shaped_out = r_s7_res;

endmodule

// ===== design/cs_checker.sv =====
// cs_checker: port-level assertions for curve_shaper_core, attached by bind.
// Depends on cs_pkg and on the top level's port names.
module cs_checker import cs_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [XW-1:0] i_shaped_out
);

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_shaped_out <= ONE))
        else $error("result above one");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_shaped_out)))
        else $error("stalled result changed");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_in_valid, i_in_ready, i_out_valid}))
        else $error("handshake signal unknown");

endmodule

bind curve_shaper_core cs_checker u_cs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_shaped_out (o_out.shaped_out)
);
